// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The condition must hold at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/scfp_pkg.sv =====
// Constants and types shared by the serial command frame parser.
package scfp_pkg;

	localparam logic [7:0] START_BYTE  = 8'h7E;
	localparam logic [7:0] FIXED_BYTE1 = 8'hFF;
	localparam logic [7:0] FIXED_BYTE2 = 8'h06;
	localparam logic [7:0] END_BYTE    = 8'hEF;

	// Frame byte positions; zero means hunting for a start byte.
	localparam logic [3:0] POS_HUNT    = 4'd0;
	localparam logic [3:0] POS_FIXED1  = 4'd1;
	localparam logic [3:0] POS_FIXED2  = 4'd2;
	localparam logic [3:0] POS_COMMAND = 4'd3;
	localparam logic [3:0] POS_PARAM_H = 4'd5;
	localparam logic [3:0] POS_PARAM_L = 4'd6;
	localparam logic [3:0] POS_CSUM_H  = 4'd7;
	localparam logic [3:0] POS_CSUM_L  = 4'd8;
	localparam logic [3:0] POS_LAST    = 4'd9;

	typedef struct packed {
		logic [7:0]  command_code;
		logic [15:0] parameter_value;
		logic        frame_valid;
	} res_t;

endpackage

// ===== sv/scfp_frame.sv =====
// Per-byte frame tracking: position counter, checksum and held fields.
module scfp_frame
	import scfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte_s1,
	output logic       emit,
	output res_t       res
);

	logic [3:0]  pos_q;
	logic [15:0] sum_q;
	logic        fixed_ok_q;
	logic [7:0]  command_q;
	logic [15:0] param_q;
	logic [7:0]  csum_hi_q;
	logic        csum_match_q;

	logic        hunting;
	logic        ok;
	logic [15:0] csum_got;
	logic [15:0] csum_want;

	// Positions ten to fifteen cannot be reached but behave as hunting.
	assign hunting   = (pos_q == POS_HUNT) || (pos_q > POS_LAST);
	assign emit      = (pos_q == POS_LAST);
	assign csum_got  = {csum_hi_q, rx_byte_s1};
	assign csum_want = 16'd0 - sum_q;
	assign ok        = fixed_ok_q && csum_match_q && (rx_byte_s1 == END_BYTE);

	always_comb begin
		res.frame_valid     = ok;
		res.command_code    = ok ? command_q : 8'd0;
		res.parameter_value = ok ? param_q : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_HUNT;
			sum_q        <= 16'd0;
			fixed_ok_q   <= 1'b1;
			command_q    <= 8'd0;
			param_q      <= 16'd0;
			csum_hi_q    <= 8'd0;
			csum_match_q <= 1'b0;
		end else if (step) begin
			if (hunting) begin
				if (rx_byte_s1 == START_BYTE) begin
					pos_q        <= POS_FIXED1;
					sum_q        <= 16'd0;
					fixed_ok_q   <= 1'b1;
					csum_match_q <= 1'b0;
				end else begin
					pos_q <= POS_HUNT;
				end
			end else begin
				if (pos_q <= POS_PARAM_L) begin
					sum_q <= sum_q + {8'd0, rx_byte_s1};
				end
				case (pos_q)
					POS_FIXED1: begin
						if (rx_byte_s1 != FIXED_BYTE1) fixed_ok_q <= 1'b0;
					end
					POS_FIXED2: begin
						if (rx_byte_s1 != FIXED_BYTE2) fixed_ok_q <= 1'b0;
					end
					POS_COMMAND: command_q <= rx_byte_s1;
					POS_PARAM_H: param_q <= {rx_byte_s1, 8'd0};
					POS_PARAM_L: param_q <= {param_q[15:8], rx_byte_s1};
					POS_CSUM_H:  csum_hi_q <= rx_byte_s1;
					POS_CSUM_L:  csum_match_q <= (csum_got == csum_want);
					default: ;
				endcase
				pos_q <= emit ? POS_HUNT : pos_q + 4'd1;
			end
		end
	end

endmodule

// ===== sv/scfp_res_reg.sv =====
// Result register that holds one finished frame until it is taken.
module scfp_res_reg
	import scfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res_d,
	output logic        free,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  command_code,
	output logic [15:0] parameter_value,
	output logic        frame_valid
);

	logic res_valid_q;
	res_t res_q;

	assign free            = !res_valid_q || !res_stall;
	assign res_valid       = res_valid_q;
	assign command_code    = res_q.command_code;
	assign parameter_value = res_q.parameter_value;
	assign frame_valid     = res_q.frame_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_d;
	end

endmodule

// ===== sv/serial_command_frame_parser.sv =====
// Serial command frame parser: takes one received byte per cycle while rx_stall
// is low and, on the tenth byte of each frame that follows a 0x7E start byte,
// delivers one result with the command byte, the 16-bit parameter and a valid
// flag (command and parameter read zero when the frame fails its fixed byte,
// end byte or checksum checks). Each accepted byte is held in the input register,
// and its result, if any, is then loaded into the result register and presented
// from there. rx_stall rises only when a tenth byte sits in the input register
// while the result register still holds an earlier frame that is being stalled.
`include "assert_macros.svh"

module serial_command_frame_parser
	import scfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  command_code,
	output logic [15:0] parameter_value,
	output logic        frame_valid
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       emit;
	logic       res_free;
	logic       advance;
	res_t       res_d;

	// A byte that ends a frame may only leave when the result register has room.
	assign advance  = valid_s1 && (!emit || res_free);
	assign rx_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) byte_s1 <= rx_byte;
	end

	scfp_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte_s1 (byte_s1),
		.emit       (emit),
		.res        (res_d)
	);

	scfp_res_reg u_res (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (advance && emit),
		.res_d           (res_d),
		.free            (res_free),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.command_code    (command_code),
		.parameter_value (parameter_value),
		.frame_valid     (frame_valid)
	);

	`ASSERT_ALWAYS(a_stall_needs_byte, !rx_stall || valid_s1, "stall without a held byte")
	`ASSERT_NEXT(a_emit_lands, advance && emit, res_valid, "finished frame lost")
	`ASSERT_ALWAYS(a_invalid_zero,
		!res_valid || frame_valid || (command_code == 8'd0 && parameter_value == 16'd0),
		"invalid frame carries data")

endmodule
